// ----- rtl/wma_pkg.sv -----
// Shared constants and types of the moving average block.
`timescale 1ns / 1ps

package wma_pkg;

  localparam int SAMPLE_W       = 32;  // sample and average width
  localparam int WIN_W          = 7;   // window length register width
  localparam int LINE_DEPTH_DEF = 64;  // default delay line depth

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SUB,
    ST_PUSH,
    ST_ACC,
    ST_DRAIN,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_OUT
  } wma_state_t;

endpackage

// ----- rtl/windowed_moving_average.sv -----
// Moving average over a sample delay line: top level with control sequencer.
//
// Each transaction on the in_ channel pushes one signed 32-bit sample into a
// LINE_DEPTH-entry delay line kept in a RAM, and one out_ transaction returns
// the mean of the newest window samples, truncated toward zero (a window of 0
// counts as 1, one above LINE_DEPTH as LINE_DEPTH). Samples not yet written
// since reset count as zero; no clearing pass is needed. One item is worked
// at a time: with an unchanged window an item goes through the running-sum
// update (one RAM read, one add) and the bit-serial divider, which retires
// one quotient bit per cycle over the sum width (38 bits at the default
// depth). The first item after a window write first rebuilds the sum from
// the RAM one entry per cycle. A finished result waits in an output
// register, so the next sample is taken while it is still unclaimed.
// Window writes are taken at any time and apply from the next item.
`timescale 1ns / 1ps

module windowed_moving_average #(
  parameter int LINE_DEPTH = wma_pkg::LINE_DEPTH_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [wma_pkg::SAMPLE_W-1:0]   in_sample,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [wma_pkg::SAMPLE_W-1:0]   out_average,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [wma_pkg::WIN_W-1:0]             cfg_window_length
);

  localparam int AW    = $clog2(LINE_DEPTH);
  localparam int FW    = $clog2(LINE_DEPTH + 1);
  localparam int WTOP  = (1 << wma_pkg::WIN_W) - 1;
  localparam int WMAX  = (LINE_DEPTH < WTOP) ? LINE_DEPTH : WTOP;
  localparam int SW    = wma_pkg::SAMPLE_W + $clog2(WMAX);
  localparam int CW    = ((AW > wma_pkg::WIN_W) ? AW : wma_pkg::WIN_W) + 1;
  localparam int EXT_W = SW - wma_pkg::SAMPLE_W;

  wma_pkg::wma_state_t state_r, state_nxt;

  logic [wma_pkg::WIN_W-1:0]           window_r;
  logic                                dirty_r;
  logic [AW-1:0]                       head_r;
  logic [FW-1:0]                       fill_r;
  logic signed [SW-1:0]                sum_r;
  logic [wma_pkg::WIN_W-1:0]           cnt_r;
  logic [wma_pkg::WIN_W-1:0]           w_r;
  logic [wma_pkg::SAMPLE_W-1:0]        sample_r;
  logic                                rd_ok_r;
  logic                                acc_pend_r;
  logic                                out_valid_r;
  logic signed [wma_pkg::SAMPLE_W-1:0] out_average_r;

  logic [wma_pkg::WIN_W-1:0]           w_eff;
  logic [wma_pkg::WIN_W-1:0]           rd_age;
  logic [CW-1:0]                       addr_t;
  logic [AW-1:0]                       raddr;
  logic [AW-1:0]                       head_inc;
  logic [wma_pkg::SAMPLE_W-1:0]        rdata;
  logic signed [SW-1:0]                sample_ext;
  logic signed [SW-1:0]                rdata_ext;
  logic                                in_accept;
  logic                                ram_we;
  logic                                div_start;
  logic                                div_done;
  logic signed [wma_pkg::SAMPLE_W-1:0] div_quo;
  logic                                out_load;

  assign in_accept  = in_valid && in_ready;
  assign cfg_ready  = 1'b1;
  assign sample_ext = {{EXT_W{sample_r[wma_pkg::SAMPLE_W-1]}}, sample_r};
  assign rdata_ext  = {{EXT_W{rdata[wma_pkg::SAMPLE_W-1]}}, rdata};

  // clamp the window to 1..LINE_DEPTH
  always_comb begin
    if (window_r == '0) begin
      w_eff = wma_pkg::WIN_W'(1);
    end else if (32'(window_r) > LINE_DEPTH) begin
      w_eff = wma_pkg::WIN_W'(LINE_DEPTH);
    end else begin
      w_eff = window_r;
    end
  end

  // age to address: newest entry sits at head, older ones below it
  always_comb begin
    addr_t = CW'(head_r) - CW'(rd_age);
    if (CW'(rd_age) > CW'(head_r)) begin
      addr_t = addr_t + CW'(LINE_DEPTH);
    end
    raddr    = addr_t[AW-1:0];
    head_inc = (32'(head_r) == LINE_DEPTH - 1) ? '0 : head_r + AW'(1);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      wma_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = dirty_r ? wma_pkg::ST_PUSH : wma_pkg::ST_SUB;
        end
      end
      wma_pkg::ST_SUB:   state_nxt = wma_pkg::ST_DIV_GO;
      wma_pkg::ST_PUSH:  state_nxt = wma_pkg::ST_ACC;
      wma_pkg::ST_ACC: begin
        if (cnt_r == w_r - wma_pkg::WIN_W'(1)) begin
          state_nxt = wma_pkg::ST_DRAIN;
        end
      end
      wma_pkg::ST_DRAIN:  state_nxt = wma_pkg::ST_DIV_GO;
      wma_pkg::ST_DIV_GO: state_nxt = wma_pkg::ST_DIV_WAIT;
      wma_pkg::ST_DIV_WAIT: begin
        if (div_done) begin
          state_nxt = wma_pkg::ST_OUT;
        end
      end
      wma_pkg::ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = wma_pkg::ST_IDLE;
        end
      end
      default: state_nxt = wma_pkg::ST_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    div_start = 1'b0;
    out_load  = 1'b0;
    rd_age    = cnt_r;
    case (state_r)
      wma_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        // fetch the entry that leaves the window
        rd_age   = w_eff - wma_pkg::WIN_W'(1);
      end
      wma_pkg::ST_SUB:    ram_we    = 1'b1;
      wma_pkg::ST_PUSH:   ram_we    = 1'b1;
      wma_pkg::ST_DIV_GO: div_start = 1'b1;
      wma_pkg::ST_OUT:    out_load  = !out_valid_r || out_ready;
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= wma_pkg::ST_IDLE;
      window_r    <= wma_pkg::WIN_W'(1);
      dirty_r     <= 1'b0;
      head_r      <= '0;
      fill_r      <= '0;
      sum_r       <= '0;
      cnt_r       <= '0;
      acc_pend_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      acc_pend_r <= (state_r == wma_pkg::ST_ACC);
      if (ram_we) begin
        head_r <= head_inc;
        if (32'(fill_r) != LINE_DEPTH) begin
          fill_r <= fill_r + FW'(1);
        end
      end
      case (state_r)
        wma_pkg::ST_SUB: begin
          sum_r <= sum_r + sample_ext - (rd_ok_r ? rdata_ext : '0);
        end
        wma_pkg::ST_PUSH: begin
          sum_r   <= '0;
          cnt_r   <= '0;
          dirty_r <= 1'b0;
        end
        wma_pkg::ST_ACC, wma_pkg::ST_DRAIN: begin
          if (state_r == wma_pkg::ST_ACC) begin
            cnt_r <= cnt_r + wma_pkg::WIN_W'(1);
          end
          if (acc_pend_r && rd_ok_r) begin
            sum_r <= sum_r + rdata_ext;
          end
        end
        default: ;
      endcase
      // a new window invalidates the running sum
      if (cfg_valid && cfg_ready) begin
        window_r <= cfg_window_length;
        dirty_r  <= 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      sample_r <= in_sample;
      w_r      <= w_eff;
    end
    // entries beyond the fill level read as zero
    rd_ok_r <= (32'(rd_age) < 32'(fill_r));
    if (out_load) begin
      out_average_r <= div_quo;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_average = out_average_r;

  wma_ram #(
    .WIDTH (wma_pkg::SAMPLE_W),
    .DEPTH (LINE_DEPTH)
  ) u_line (
    .clk   (clk),
    .we    (ram_we),
    .waddr (head_inc),
    .wdata (sample_r),
    .raddr (raddr),
    .rdata (rdata)
  );

  wma_div #(
    .SW (SW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (sum_r),
    .divisor  (w_r),
    .done     (div_done),
    .quotient (div_quo)
  );

endmodule

// ----- rtl/wma_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module wma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/wma_div.sv -----
// Bit-serial signed divider: window sum divided by window length, truncated toward zero.
`timescale 1ns / 1ps

module wma_div #(
  parameter int SW = 38
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  input  logic signed [SW-1:0]            dividend,
  input  logic [wma_pkg::WIN_W-1:0]       divisor,
  output logic                            done,
  output logic signed [wma_pkg::SAMPLE_W-1:0] quotient
);

  localparam int CNT_W = $clog2(SW + 1);

  logic                             run_r;
  logic                             fix_r;
  logic                             done_r;
  logic [CNT_W-1:0]                 cnt_r;
  logic                             neg_r;
  logic [SW-1:0]                    q_r;
  logic [wma_pkg::WIN_W-1:0]        rem_r;
  logic signed [wma_pkg::SAMPLE_W-1:0] quo_r;

  logic [wma_pkg::WIN_W:0]          trial;
  logic                             ge;
  logic [wma_pkg::WIN_W:0]          diff;
  logic [SW-1:0]                    q_neg;

  always_comb begin
    trial = {rem_r, q_r[SW-1]};
    ge    = (trial >= {1'b0, divisor});
    diff  = trial - {1'b0, divisor};
    q_neg = ~q_r + SW'(1);
  end

  // sequencing control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      fix_r  <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= CNT_W'(SW);
      end else if (run_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          run_r <= 1'b0;
          fix_r <= 1'b1;
        end
      end else if (fix_r) begin
        done_r <= 1'b1;
      end
    end
  end

  // magnitude shift register, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[SW-1];
      q_r   <= dividend[SW-1] ? (~dividend + SW'(1)) : dividend;
      rem_r <= '0;
    end else if (run_r) begin
      rem_r <= ge ? diff[wma_pkg::WIN_W-1:0] : trial[wma_pkg::WIN_W-1:0];
      q_r   <= {q_r[SW-2:0], ge};
    end
    if (fix_r) begin
      quo_r <= neg_r ? q_neg[wma_pkg::SAMPLE_W-1:0] : q_r[wma_pkg::SAMPLE_W-1:0];
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

// ----- rtl/wma_checker.sv -----
// Port-level checks for the moving average block, bound to its top level.
`timescale 1ns / 1ps

module wma_checker (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic                                out_ready,
  input logic signed [wma_pkg::SAMPLE_W-1:0] out_average
);

  logic       in_acc;
  logic       out_acc;
  logic [1:0] pend_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  // transactions taken but not yet delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_r <= '0;
    end else if (in_acc && !out_acc) begin
      pend_r <= pend_r + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_r <= pend_r - 2'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_average))
    else $error("result changed or dropped while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> !in_ready)
    else $error("input taken while an item is in work");

  a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pend_r != 2'd3)
    else $error("more than two transactions outstanding");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pend_r != 2'd0)
    else $error("result shown with no transaction outstanding");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind windowed_moving_average wma_checker u_wma_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_valid),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .out_average (out_average)
);
